[design/dwhf_pkg.sv]
// shared types, codes and constants of the wave height field stepper
`timescale 1ns / 1ps
`default_nettype none
package dwhf_pkg;

  localparam int unsigned GRID_W_DEF = 16;
  localparam int unsigned GRID_H_DEF = 16;

  localparam int unsigned HW = 16;   // height width, signed Q3.12
  localparam int unsigned CW = 16;   // coefficient width, unsigned Q0.16
  localparam int unsigned LW = 19;   // laplacian sum width
  localparam int unsigned MW = 18;   // 2*centre - previous width

  localparam logic [CW-1:0] COUPLING_RST = 16'd1820;
  localparam logic [CW-1:0] DAMPING_RST  = 16'd63570;

  // configuration register indexes
  localparam logic CFG_COUPLING = 1'b0;
  localparam logic CFG_DAMPING  = 1'b1;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_READ = 2'd1,
    ACT_STEP = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  // which addresses the two grid read ports look at
  typedef enum logic [1:0] {
    RP_CELL = 2'd0,
    RP_LR   = 2'd1,
    RP_UD   = 2'd2,
    RP_CP   = 2'd3
  } rd_phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_READ,
    ST_READ_WAIT,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_MUL0,
    ST_MUL1,
    ST_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic      latch;     // take the request fields
    logic      load_wr;   // write the loaded height into both grids
    rd_phase_t rd_phase;
    logic      cap_read;  // keep the current-grid height for a read
    logic      cap_rl;
    logic      cap_ud;
    logic      cap_cp;
    logic      mul_c;
    logic      mul_d;
    logic      cell_wr;   // write the new height and move to the next cell
    logic      swap;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic last_cell;
  } sts_t;

endpackage
`default_nettype wire

[design/dwhf_ctrl.sv]
// controller state machine of the wave height field stepper
`timescale 1ns / 1ps
`default_nettype none
module dwhf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [1:0]    in_action,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output dwhf_pkg::cmd_t     cmd,
  input  wire dwhf_pkg::sts_t sts
);

  dwhf_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic in_acc;
  logic out_free;

  assign in_stall  = (state_r != dwhf_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dwhf_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (dwhf_pkg::action_t'(in_action))
            dwhf_pkg::ACT_LOAD: state_nxt = dwhf_pkg::ST_LOAD;
            dwhf_pkg::ACT_READ: state_nxt = dwhf_pkg::ST_READ;
            dwhf_pkg::ACT_STEP: state_nxt = dwhf_pkg::ST_RD0;
            default:            state_nxt = dwhf_pkg::ST_DONE;
          endcase
        end
      end
      dwhf_pkg::ST_LOAD:      state_nxt = dwhf_pkg::ST_DONE;
      dwhf_pkg::ST_READ:      state_nxt = dwhf_pkg::ST_READ_WAIT;
      dwhf_pkg::ST_READ_WAIT: state_nxt = dwhf_pkg::ST_DONE;
      dwhf_pkg::ST_RD0:       state_nxt = dwhf_pkg::ST_RD1;
      dwhf_pkg::ST_RD1:       state_nxt = dwhf_pkg::ST_RD2;
      dwhf_pkg::ST_RD2:       state_nxt = dwhf_pkg::ST_RD3;
      dwhf_pkg::ST_RD3:       state_nxt = dwhf_pkg::ST_MUL0;
      dwhf_pkg::ST_MUL0:      state_nxt = dwhf_pkg::ST_MUL1;
      dwhf_pkg::ST_MUL1:      state_nxt = dwhf_pkg::ST_WR;
      dwhf_pkg::ST_WR: begin
        state_nxt = sts.last_cell ? dwhf_pkg::ST_DONE : dwhf_pkg::ST_RD0;
      end
      dwhf_pkg::ST_DONE: begin
        if (out_free) state_nxt = dwhf_pkg::ST_IDLE;
      end
      default:                state_nxt = dwhf_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    cmd.rd_phase = dwhf_pkg::RP_CELL;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;
    case (state_r)
      dwhf_pkg::ST_IDLE:      cmd.latch = in_acc;
      dwhf_pkg::ST_LOAD:      cmd.load_wr = 1'b1;
      dwhf_pkg::ST_READ:      cmd.rd_phase = dwhf_pkg::RP_CELL;
      dwhf_pkg::ST_READ_WAIT: cmd.cap_read = 1'b1;
      dwhf_pkg::ST_RD0:       cmd.rd_phase = dwhf_pkg::RP_LR;
      dwhf_pkg::ST_RD1: begin
        cmd.rd_phase = dwhf_pkg::RP_UD;
        cmd.cap_rl   = 1'b1;
      end
      dwhf_pkg::ST_RD2: begin
        cmd.rd_phase = dwhf_pkg::RP_CP;
        cmd.cap_ud   = 1'b1;
      end
      dwhf_pkg::ST_RD3:       cmd.cap_cp = 1'b1;
      dwhf_pkg::ST_MUL0:      cmd.mul_c = 1'b1;
      dwhf_pkg::ST_MUL1:      cmd.mul_d = 1'b1;
      dwhf_pkg::ST_WR: begin
        cmd.cell_wr = 1'b1;
        cmd.swap    = sts.last_cell;
      end
      dwhf_pkg::ST_DONE: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dwhf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_done_posts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dwhf_pkg::ST_DONE && out_free) |=>
      (out_valid_r && state_r == dwhf_pkg::ST_IDLE))
    else $error("finished request not posted");

  a_walk_on: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dwhf_pkg::ST_WR && !sts.last_cell) |=> (state_r == dwhf_pkg::ST_RD0))
    else $error("step walk stopped early");

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != dwhf_pkg::ST_IDLE) |=> (in_stall || $past(state_r) == dwhf_pkg::ST_DONE))
    else $error("request taken while busy");

endmodule
`default_nettype wire

[design/dwhf_dp.sv]
// datapath of the wave height field stepper: grids, stencil, multiply, saturate
`timescale 1ns / 1ps
`default_nettype none
module dwhf_dp #(
  parameter int unsigned GRID_W = dwhf_pkg::GRID_W_DEF,
  parameter int unsigned GRID_H = dwhf_pkg::GRID_H_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic                    cfg_index,
  input  wire logic [dwhf_pkg::CW-1:0] cfg_data,
  input  wire logic [3:0]              in_cell_x,
  input  wire logic [3:0]              in_cell_y,
  input  wire logic signed [dwhf_pkg::HW-1:0] in_height_in,
  output logic signed [dwhf_pkg::HW-1:0]      out_height_out,
  output logic                         out_saturated,
  input  wire dwhf_pkg::cmd_t          cmd,
  output dwhf_pkg::sts_t               sts
);

  localparam int unsigned CELLS = GRID_W * GRID_H;
  localparam int unsigned AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned XW = $clog2(GRID_W);
  localparam int unsigned YW = $clog2(GRID_H);
  localparam int unsigned HW = dwhf_pkg::HW;
  localparam int unsigned CW = dwhf_pkg::CW;
  localparam int unsigned LW = dwhf_pkg::LW;
  localparam int unsigned MW = dwhf_pkg::MW;
  localparam int unsigned PCW = LW + CW + 1;
  localparam int unsigned PDW = MW + CW + 1;
  localparam int unsigned SW = PCW - CW + 1;

  function automatic logic [AW-1:0] addr_of(input logic [XW-1:0] x, input logic [YW-1:0] y);
    addr_of = AW'(32'(y) * GRID_W + 32'(x));
  endfunction

  logic [CW-1:0] coup_r, damp_r;
  logic          sel_r;
  logic [AW-1:0] item_addr_r;
  logic          in_grid_r;
  logic signed [HW-1:0] item_h_r;
  logic [XW-1:0] i_r;
  logic [YW-1:0] j_r;

  logic signed [HW-1:0] mem_a [CELLS];
  logic signed [HW-1:0] mem_b [CELLS];
  logic signed [HW-1:0] rd0_a_r, rd1_a_r, rd0_b_r, rd1_b_r;
  logic [AW-1:0] ra0, ra1, wa;
  logic signed [HW-1:0] wd;
  logic we_a, we_b;

  logic signed [LW-1:0]  acc_r, lap_r;
  logic signed [MW-1:0]  mom_r;
  logic signed [PCW-1:0] prod_c_r;
  logic signed [PDW-1:0] prod_d_r;
  logic signed [HW-1:0]  res_h_r;
  logic                  sat_r;
  logic signed [HW-1:0]  out_h_r;
  logic                  out_sat_r;

  logic signed [HW-1:0] cur0, cur1, prv1;
  logic [XW-1:0] ir, il;
  logic [YW-1:0] ju, jd;
  logic [AW-1:0] p_addr;
  logic signed [SW-1:0] sum;
  logic signed [HW-1:0] sat_val;
  logic                 sat_hit;
  logic [31:0] item_lin;
  logic        item_in;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coup_r <= dwhf_pkg::COUPLING_RST;
      damp_r <= dwhf_pkg::DAMPING_RST;
    end else if (cfg_we) begin
      if (cfg_index == dwhf_pkg::CFG_COUPLING) coup_r <= cfg_data;
      else                                     damp_r <= cfg_data;
    end
  end

  // request decode
  assign item_in  = (32'(in_cell_x) < GRID_W) && (32'(in_cell_y) < GRID_H);
  assign item_lin = 32'(in_cell_y) * GRID_W + 32'(in_cell_x);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_addr_r <= item_lin[AW-1:0];
      in_grid_r   <= item_in;
      item_h_r    <= in_height_in;
    end
  end

  // cell walk counters; neighbours are mirrored at the low edges and clamped at the high edges
  assign ir = (i_r == XW'(GRID_W - 1)) ? i_r : i_r + XW'(1);
  assign il = (i_r == '0) ? XW'(1) : i_r - XW'(1);
  assign jd = (j_r == YW'(GRID_H - 1)) ? j_r : j_r + YW'(1);
  assign ju = (j_r == '0) ? YW'(1) : j_r - YW'(1);
  assign p_addr = addr_of(i_r, j_r);
  assign sts.last_cell = (i_r == XW'(GRID_W - 1)) && (j_r == YW'(GRID_H - 1));

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      i_r <= '0;
      j_r <= '0;
    end else if (cmd.cell_wr) begin
      if (i_r == XW'(GRID_W - 1)) begin
        i_r <= '0;
        j_r <= j_r + YW'(1);
      end else begin
        i_r <= i_r + XW'(1);
      end
    end
  end

  // read address selection
  always_comb begin
    case (cmd.rd_phase)
      dwhf_pkg::RP_LR: begin
        ra0 = addr_of(ir, j_r);
        ra1 = addr_of(il, j_r);
      end
      dwhf_pkg::RP_UD: begin
        ra0 = addr_of(i_r, ju);
        ra1 = addr_of(i_r, jd);
      end
      dwhf_pkg::RP_CP: begin
        ra0 = p_addr;
        ra1 = p_addr;
      end
      default: begin
        ra0 = item_addr_r;
        ra1 = item_addr_r;
      end
    endcase
  end

  // write port: load hits both grids, a step writes the previous grid
  assign wa   = cmd.load_wr ? item_addr_r : p_addr;
  assign wd   = cmd.load_wr ? item_h_r : sat_val;
  assign we_a = (cmd.load_wr && in_grid_r) || (cmd.cell_wr && sel_r);
  assign we_b = (cmd.load_wr && in_grid_r) || (cmd.cell_wr && !sel_r);

  // grid memories
  always_ff @(posedge clk) begin
    if (we_a) mem_a[wa] <= wd;
    rd0_a_r <= mem_a[ra0];
    rd1_a_r <= mem_a[ra1];
  end

  always_ff @(posedge clk) begin
    if (we_b) mem_b[wa] <= wd;
    rd0_b_r <= mem_b[ra0];
    rd1_b_r <= mem_b[ra1];
  end

  assign cur0 = sel_r ? rd0_b_r : rd0_a_r;
  assign cur1 = sel_r ? rd1_b_r : rd1_a_r;
  assign prv1 = sel_r ? rd1_a_r : rd1_b_r;

  // stencil sums
  always_ff @(posedge clk) begin
    if (cmd.cap_rl) acc_r <= LW'(cur0) + LW'(cur1);
    else if (cmd.cap_ud) acc_r <= acc_r + LW'(cur0) + LW'(cur1);
    if (cmd.cap_cp) begin
      lap_r <= acc_r - (LW'(cur0) <<< 2);
      mom_r <= (MW'(cur0) <<< 1) - MW'(prv1);
    end
  end

  // coefficient products, one multiplier each cycle
  always_ff @(posedge clk) begin
    if (cmd.mul_c) prod_c_r <= PCW'(lap_r) * $signed({1'b0, coup_r});
    if (cmd.mul_d) prod_d_r <= PDW'(mom_r) * $signed({1'b0, damp_r});
  end

  // drop fractions (floor), add, saturate
  assign sum = SW'($signed(prod_c_r[PCW-1:CW])) + SW'($signed(prod_d_r[PDW-1:CW]));
  always_comb begin
    sat_hit = 1'b0;
    if (sum > SW'(32767)) begin
      sat_val = 16'sh7FFF;
      sat_hit = 1'b1;
    end else if (sum < -SW'(32768)) begin
      sat_val = -16'sh8000;
      sat_hit = 1'b1;
    end else begin
      sat_val = sum[HW-1:0];
    end
  end

  // result of the request and current grid select
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
      sat_r <= 1'b0;
    end else begin
      if (cmd.swap) sel_r <= !sel_r;
      if (cmd.latch) sat_r <= 1'b0;
      else if (cmd.cell_wr && sat_hit) sat_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) res_h_r <= '0;
    else if (cmd.cap_read) res_h_r <= in_grid_r ? cur0 : '0;
    if (cmd.out_load) begin
      out_h_r   <= res_h_r;
      out_sat_r <= sat_r;
    end
  end

  assign out_height_out = out_h_r;
  assign out_saturated  = out_sat_r;

endmodule
`default_nettype wire

[design/damped_wave_height_field_step.sv]
// top level of the damped wave height field stepper
`timescale 1ns / 1ps
`default_nettype none
// Keeps a current and a previous GRID_W x GRID_H grid of Q3.12 heights in two
// memories and answers every request with one result. A load passes the LOAD
// and DONE states and a read the READ, READ_WAIT and DONE states after the
// accepting cycle, and DONE posts the result. A time step walks every cell
// once through a shared read, multiply and saturate sequence of the states
// RD0 to RD3, MUL0, MUL1 and WR, using the two read ports on each grid memory
// and a single multiply in each of MUL0 and MUL1.
// The next request is taken once the previous result is posted, while that
// result may still wait on out_stall. No clearing pass follows reset.
module damped_wave_height_field_step #(
  parameter int unsigned GRID_W = dwhf_pkg::GRID_W_DEF,
  parameter int unsigned GRID_H = dwhf_pkg::GRID_H_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic                    cfg_index,
  input  wire logic [dwhf_pkg::CW-1:0] cfg_data,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [1:0]              in_action,
  input  wire logic [3:0]              in_cell_x,
  input  wire logic [3:0]              in_cell_y,
  input  wire logic signed [dwhf_pkg::HW-1:0] in_height_in,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [dwhf_pkg::HW-1:0] out_height_out,
  output logic                         out_saturated
);

  dwhf_pkg::cmd_t cmd;
  dwhf_pkg::sts_t sts;

  dwhf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  dwhf_dp #(
    .GRID_W (GRID_W),
    .GRID_H (GRID_H)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_cell_x      (in_cell_x),
    .in_cell_y      (in_cell_y),
    .in_height_in   (in_height_in),
    .out_height_out (out_height_out),
    .out_saturated  (out_saturated),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule
`default_nettype wire
